@@ hw/rtl/dmem_pkg.sv @@
// Shared constants, types and register codes for the dual-mask edge magnitude block.
package dmem_pkg;

  // Image geometry limits and the smallest frame the block handles.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MIN_SIZE   = 3;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // Fixed field widths of the channels.
  localparam int PIX_W      = 8;
  localparam int COEF_W     = 8;
  localparam int COORD_W    = 10;
  localparam int SIZE_W     = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Queue between the pixel front end and the arithmetic back end.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_LVL_W = $clog2(FIFO_DEPTH + 1);

  typedef logic [PIX_W-1:0]   pix_t;
  typedef logic [COORD_W-1:0] coord_t;

  // Window and masks share one shape: [row top..bottom][column left..right].
  typedef logic [2:0][2:0][PIX_W-1:0]  window_t;
  typedef logic [2:0][2:0][COEF_W-1:0] mask_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MASK_A_ROW0,
    REG_MASK_A_ROW1,
    REG_MASK_A_ROW2,
    REG_MASK_B_ROW0,
    REG_MASK_B_ROW1,
    REG_MASK_B_ROW2,
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT
  } cfg_reg_e;

  // Reset values: diagonal Roberts masks and a 512 x 512 frame.
  localparam mask_t MASK_A_RESET = {24'h000000, 24'h000100, 24'h0000FF};
  localparam mask_t MASK_B_RESET = {24'h000000, 24'h000100, 24'hFF0000};
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(512);

  // Position and frame marker that travel with each window.
  typedef struct packed {
    coord_t row;
    coord_t col;
    logic   last;
  } meta_t;

  typedef struct packed {
    window_t win;
    meta_t   meta;
  } q_entry_t;

  typedef struct packed {
    logic                  empty;
    logic [FIFO_LVL_W-1:0] level;
  } q_status_t;

endpackage

@@ hw/rtl/dmem_channels.sv @@
// Handshake channels for pixels, results and configuration writes.
interface dmem_pixel_if import dmem_pkg::*; ();
  logic valid;
  logic ready;
  pix_t pixel;

  modport source(output valid, output pixel, input ready);
  modport sink(input valid, input pixel, output ready);
endinterface

interface dmem_result_if import dmem_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] edge_magnitude;
  logic [7:0] response_a_abs;
  logic [7:0] response_b_abs;
  coord_t     center_row;
  coord_t     center_col;
  logic       last_of_frame;

  modport source(output valid, output edge_magnitude, output response_a_abs,
                 output response_b_abs, output center_row, output center_col,
                 output last_of_frame, input ready);
  modport sink(input valid, input edge_magnitude, input response_a_abs,
               input response_b_abs, input center_row, input center_col,
               input last_of_frame, output ready);
endinterface

interface dmem_cfg_if import dmem_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/dmem_front.sv @@
// Pixel front end: raster position, two line stores, 3x3 window and queue push.
module dmem_front import dmem_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  dmem_pixel_if.sink        pixels,
  input  logic [SIZE_W-1:0] image_width,
  input  logic [SIZE_W-1:0] image_height,
  input  q_status_t         q_stat,
  output logic              q_push,
  output q_entry_t          q_data
);

  localparam int DIM_W0 = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int DIM_W  = ((DIM_W0 > SIZE_W) ? DIM_W0 : SIZE_W) + 1;

  function automatic logic [DIM_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                  input int unsigned maxv);
    logic [DIM_W-1:0] vx;
    vx = DIM_W'(v);
    if (vx < DIM_W'(MIN_SIZE)) return DIM_W'(MIN_SIZE);
    if (vx > DIM_W'(maxv)) return DIM_W'(maxv);
    return vx;
  endfunction

  logic [DIM_W-1:0] w;
  logic [DIM_W-1:0] h;
  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;
  logic [DIM_W-1:0] row_step;
  logic [DIM_W-1:0] col_step;
  logic [DIM_W-1:0] row_inc;
  logic             accept;
  logic             emit;
  logic             last;

  // Line stores: the row just above and the row two above.
  pix_t line_near [MAX_WIDTH];
  pix_t line_far  [MAX_WIDTH];
  pix_t near_rd;
  pix_t far_rd;

  // One stage between the store read and the window.
  logic             s1_valid;
  logic             s1_emit;
  logic             s1_last;
  logic [ROW_W-1:0] s1_row;
  logic [COL_W-1:0] s1_col;
  pix_t             s1_pixel;

  window_t window;
  window_t window_next;

  // Accept only while the queue has room for every item still in flight.
  assign pixels.ready = !rst &&
    ((q_stat.level + FIFO_LVL_W'(s1_valid && s1_emit)) < FIFO_LVL_W'(FIFO_DEPTH));
  assign accept = pixels.valid && pixels.ready;

  // Position of the incoming pixel, wrapping when the frame size has shrunk.
  always_comb begin
    w = clamp_size(image_width, MAX_WIDTH);
    h = clamp_size(image_height, MAX_HEIGHT);
    if (DIM_W'(col_count) >= w) begin
      cur_col  = '0;
      row_step = DIM_W'(row_count) + DIM_W'(1);
    end else begin
      cur_col  = col_count;
      row_step = DIM_W'(row_count);
    end
    cur_row  = (row_step >= h) ? '0 : ROW_W'(row_step);
    col_step = DIM_W'(cur_col) + DIM_W'(1);
    row_inc  = DIM_W'(cur_row) + DIM_W'(1);
    emit     = (DIM_W'(cur_row) >= DIM_W'(2)) && (DIM_W'(cur_col) >= DIM_W'(2));
    last     = (row_inc == h) && (col_step == w);
  end

  // Raster counters advance once per accepted pixel.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (col_step >= w) begin
        col_count <= '0;
        row_count <= (row_inc >= h) ? '0 : ROW_W'(row_inc);
      end else begin
        col_count <= COL_W'(col_step);
        row_count <= cur_row;
      end
    end
  end

  // Near store: read the old value, then overwrite it with the new pixel.
  always_ff @(posedge clk) begin
    if (accept) begin
      near_rd            <= line_near[cur_col];
      line_near[cur_col] <= pixels.pixel;
    end
  end

  // Far store: read now, and take the near value in the next cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      far_rd <= line_far[cur_col];
    end
    if (s1_valid) begin
      line_far[s1_col] <= near_rd;
    end
  end

  // Stage 1 control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_emit  <= 1'b0;
    end else begin
      s1_valid <= accept;
      s1_emit  <= accept && emit;
    end
  end

  // Stage 1 payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_last  <= last;
      s1_row   <= cur_row;
      s1_col   <= cur_col;
      s1_pixel <= pixels.pixel;
    end
  end

  // Shift the window left and bring in the new right-hand column.
  always_comb begin
    window_next = window;
    for (int k = 0; k < 3; k++) begin
      window_next[k][0] = window[k][1];
      window_next[k][1] = window[k][2];
    end
    window_next[0][2] = far_rd;
    window_next[1][2] = near_rd;
    window_next[2][2] = s1_pixel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (s1_valid) begin
      window <= window_next;
    end
  end

  // Interior pixels hand their window to the queue.
  assign q_push           = s1_valid && s1_emit;
  assign q_data.win       = window_next;
  assign q_data.meta.row  = COORD_W'(s1_row - ROW_W'(1));
  assign q_data.meta.col  = COORD_W'(s1_col - COL_W'(1));
  assign q_data.meta.last = s1_last;

endmodule

@@ hw/rtl/dmem_fifo.sv @@
// Small register queue that decouples the pixel front end from the back end.
module dmem_fifo import dmem_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  q_entry_t  push_data,
  input  logic      pop,
  output q_entry_t  pop_data,
  output q_status_t status
);

  q_entry_t              slots [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_LVL_W-1:0] level;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      case ({push, pop})
        2'b10:   level <= level + FIFO_LVL_W'(1);
        2'b01:   level <= level - FIFO_LVL_W'(1);
        default: level <= level;
      endcase
    end
  end

  assign pop_data     = slots[rd_ptr];
  assign status.empty = (level == '0);
  assign status.level = level;

endmodule

@@ hw/rtl/dmem_back.sv @@
// Arithmetic back end: mask responses, magnitudes, pipelined rounded root, output register.
module dmem_back import dmem_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  mask_t        mask_a,
  input  mask_t        mask_b,
  input  q_entry_t     q_data,
  input  q_status_t    q_stat,
  output logic         q_pop,
  dmem_result_if.source results
);

  localparam int PROD_W          = PIX_W + COEF_W + 1;
  localparam int SUM_W           = PROD_W + 4;
  localparam int CLIP_W          = PIX_W + 1;
  localparam int SQ_W            = 2 * CLIP_W;
  localparam int ROOT_W          = 8;
  localparam int RAD_W           = 2 * ROOT_W;
  localparam int REM_W           = ROOT_W + 2;
  localparam int CAND_W          = REM_W + 2;
  localparam int STEPS_PER_STAGE = 2;
  localparam int ROOT_STAGES     = ROOT_W / STEPS_PER_STAGE;
  localparam int PIX_MAX         = (1 << PIX_W) - 1;
  localparam int SAT_LIMIT       = ((1 << ROOT_W) - 1) * (1 << ROOT_W);

  typedef struct packed {
    meta_t            meta;
    logic [PIX_W-1:0] abs_a;
    logic [PIX_W-1:0] abs_b;
    logic             sat;
  } tail_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } root_acc_t;

  // One digit of the restoring square root: two radicand bits in, one root bit out.
  function automatic root_acc_t root_step(input root_acc_t acc, input logic [1:0] pair);
    logic [CAND_W-1:0] cand;
    logic [CAND_W-1:0] trial;
    root_acc_t         res;
    cand  = {acc.rem, pair};
    trial = CAND_W'({acc.root, 2'b01});
    if (cand >= trial) begin
      res.rem  = REM_W'(cand - trial);
      res.root = {acc.root[ROOT_W-2:0], 1'b1};
    end else begin
      res.rem  = REM_W'(cand);
      res.root = {acc.root[ROOT_W-2:0], 1'b0};
    end
    return res;
  endfunction

  function automatic logic [SUM_W-1:0] magnitude(input logic signed [SUM_W-1:0] v);
    return v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
  endfunction

  logic en;

  // Stage 0: coefficient products.
  logic                     v0;
  meta_t                    meta0;
  logic signed [PROD_W-1:0] prod_a [3][3];
  logic signed [PROD_W-1:0] prod_b [3][3];

  // Stage 1: mask responses.
  logic                    v1;
  meta_t                   meta1;
  logic signed [SUM_W-1:0] sum_a;
  logic signed [SUM_W-1:0] sum_b;
  logic signed [SUM_W-1:0] sum_a_next;
  logic signed [SUM_W-1:0] sum_b_next;

  // Stage 2: absolute values.
  logic              v2;
  tail_t             tail2;
  logic [CLIP_W-1:0] clip_a;
  logic [CLIP_W-1:0] clip_b;
  logic [SUM_W-1:0]  mag_a;
  logic [SUM_W-1:0]  mag_b;

  // Stage 3: sum of squares.
  logic             v3;
  tail_t            tail3;
  logic [RAD_W-1:0] rad3;
  logic [SQ_W-1:0]  sq_sum;

  // Root stages.
  logic             rv    [ROOT_STAGES];
  tail_t            rtail [ROOT_STAGES];
  root_acc_t        racc  [ROOT_STAGES];
  logic [RAD_W-1:0] rrad  [ROOT_STAGES];
  logic             src_v    [ROOT_STAGES];
  tail_t            src_tail [ROOT_STAGES];
  root_acc_t        src_acc  [ROOT_STAGES];
  logic [RAD_W-1:0] src_rad  [ROOT_STAGES];
  root_acc_t        step_acc [ROOT_STAGES];
  logic [RAD_W-1:0] step_rad [ROOT_STAGES];

  root_acc_t fin;

  // The whole pipe moves whenever the output register can take an item.
  assign en    = !results.valid || results.ready;
  assign q_pop = en && !q_stat.empty;

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0            <= 1'b0;
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      results.valid <= 1'b0;
      for (int k = 0; k < ROOT_STAGES; k++) rv[k] <= 1'b0;
    end else if (en) begin
      v0            <= q_pop;
      v1            <= v0;
      v2            <= v1;
      v3            <= v2;
      results.valid <= rv[ROOT_STAGES-1];
      for (int k = 0; k < ROOT_STAGES; k++) rv[k] <= src_v[k];
    end
  end

  // Products of each coefficient with its window pixel.
  always_ff @(posedge clk) begin
    if (en) begin
      meta0 <= q_data.meta;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_a[i][j] <= PROD_W'($signed(mask_a[i][j])) *
                          PROD_W'($signed({1'b0, q_data.win[i][j]}));
          prod_b[i][j] <= PROD_W'($signed(mask_b[i][j])) *
                          PROD_W'($signed({1'b0, q_data.win[i][j]}));
        end
      end
    end
  end

  // Adder trees for both responses.
  always_comb begin
    sum_a_next = '0;
    sum_b_next = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        sum_a_next = sum_a_next + SUM_W'(prod_a[i][j]);
        sum_b_next = sum_b_next + SUM_W'(prod_b[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta1 <= meta0;
      sum_a <= sum_a_next;
      sum_b <= sum_b_next;
    end
  end

  // Absolute values, saturated for output and clipped for squaring.
  assign mag_a = magnitude(sum_a);
  assign mag_b = magnitude(sum_b);

  always_ff @(posedge clk) begin
    if (en) begin
      tail2.meta  <= meta1;
      tail2.sat   <= 1'b0;
      tail2.abs_a <= (mag_a > SUM_W'(PIX_MAX)) ? PIX_W'(PIX_MAX) : mag_a[PIX_W-1:0];
      tail2.abs_b <= (mag_b > SUM_W'(PIX_MAX)) ? PIX_W'(PIX_MAX) : mag_b[PIX_W-1:0];
      clip_a      <= (mag_a > SUM_W'(PIX_MAX)) ? CLIP_W'(PIX_MAX + 1) : mag_a[CLIP_W-1:0];
      clip_b      <= (mag_b > SUM_W'(PIX_MAX)) ? CLIP_W'(PIX_MAX + 1) : mag_b[CLIP_W-1:0];
    end
  end

  // Sum of squares; anything above the limit rounds to full scale.
  assign sq_sum = SQ_W'(clip_a) * SQ_W'(clip_a) + SQ_W'(clip_b) * SQ_W'(clip_b);

  always_ff @(posedge clk) begin
    if (en) begin
      tail3.meta  <= tail2.meta;
      tail3.abs_a <= tail2.abs_a;
      tail3.abs_b <= tail2.abs_b;
      tail3.sat   <= sq_sum > SQ_W'(SAT_LIMIT);
      rad3        <= sq_sum[RAD_W-1:0];
    end
  end

  // Each root stage resolves two result bits.
  always_comb begin
    src_v[0]    = v3;
    src_tail[0] = tail3;
    src_acc[0]  = '0;
    src_rad[0]  = rad3;
    for (int k = 1; k < ROOT_STAGES; k++) begin
      src_v[k]    = rv[k-1];
      src_tail[k] = rtail[k-1];
      src_acc[k]  = racc[k-1];
      src_rad[k]  = rrad[k-1];
    end
    for (int k = 0; k < ROOT_STAGES; k++) begin
      step_acc[k] = src_acc[k];
      step_rad[k] = src_rad[k];
      for (int s = 0; s < STEPS_PER_STAGE; s++) begin
        step_acc[k] = root_step(step_acc[k], step_rad[k][RAD_W-1 -: 2]);
        step_rad[k] = {step_rad[k][RAD_W-3:0], 2'b00};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < ROOT_STAGES; k++) begin
        rtail[k] <= src_tail[k];
        racc[k]  <= step_acc[k];
        rrad[k]  <= step_rad[k];
      end
    end
  end

  // Round to nearest: step up when the remainder exceeds the floor root.
  assign fin = racc[ROOT_STAGES-1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (rtail[ROOT_STAGES-1].sat) begin
        results.edge_magnitude <= PIX_W'(PIX_MAX);
      end else if (fin.rem > REM_W'(fin.root)) begin
        results.edge_magnitude <= fin.root + ROOT_W'(1);
      end else begin
        results.edge_magnitude <= fin.root;
      end
      results.response_a_abs <= rtail[ROOT_STAGES-1].abs_a;
      results.response_b_abs <= rtail[ROOT_STAGES-1].abs_b;
      results.center_row     <= rtail[ROOT_STAGES-1].meta.row;
      results.center_col     <= rtail[ROOT_STAGES-1].meta.col;
      results.last_of_frame  <= rtail[ROOT_STAGES-1].meta.last;
    end
  end

endmodule

@@ hw/rtl/dual_mask_edge_magnitude.sv @@
// Top level of the dual-mask 3x3 edge magnitude block with its configuration registers.
// Grey pixels enter in raster order at up to one per clock; each interior pixel yields one
// item with the rounded root of the two squared mask responses, both absolute responses
// and the window centre position, while border pixels yield nothing. The front end keeps
// two line stores of 1024 pixels, each read and written once per pixel, so the sustained
// rate is one pixel per cycle while results are taken; an item passes the products, sums,
// absolute values, squares and two-bits-per-stage square root to the output register.
// A four-entry queue sits between front and back end, and the input stalls only when that
// queue and the pixels in flight would overfill it because the result side is not taking
// items. The line stores need no clearing after reset. Configuration writes are taken in
// any cycle outside reset and should only be issued while the block is idle.
module dual_mask_edge_magnitude import dmem_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  dmem_pixel_if.sink    pixels,
  dmem_cfg_if.sink      cfg,
  dmem_result_if.source results
);

  mask_t             mask_a;
  mask_t             mask_b;
  logic [SIZE_W-1:0] image_width;
  logic [SIZE_W-1:0] image_height;

  logic      q_push;
  logic      q_pop;
  q_entry_t  q_in;
  q_entry_t  q_out;
  q_status_t q_stat;

  // Configuration registers.
  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_a       <= MASK_A_RESET;
      mask_b       <= MASK_B_RESET;
      image_width  <= SIZE_RESET;
      image_height <= SIZE_RESET;
    end else if (cfg.valid) begin
      unique case (cfg_reg_e'(cfg.index))
        REG_MASK_A_ROW0:  mask_a[0]    <= cfg.data;
        REG_MASK_A_ROW1:  mask_a[1]    <= cfg.data;
        REG_MASK_A_ROW2:  mask_a[2]    <= cfg.data;
        REG_MASK_B_ROW0:  mask_b[0]    <= cfg.data;
        REG_MASK_B_ROW1:  mask_b[1]    <= cfg.data;
        REG_MASK_B_ROW2:  mask_b[2]    <= cfg.data;
        REG_IMAGE_WIDTH:  image_width  <= cfg.data[SIZE_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg.data[SIZE_W-1:0];
      endcase
    end
  end

  dmem_front u_front (
    .clk          (clk),
    .rst          (rst),
    .pixels       (pixels),
    .image_width  (image_width),
    .image_height (image_height),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_data       (q_in)
  );

  dmem_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .status    (q_stat)
  );

  dmem_back u_back (
    .clk     (clk),
    .rst     (rst),
    .mask_a  (mask_a),
    .mask_b  (mask_b),
    .q_data  (q_out),
    .q_stat  (q_stat),
    .q_pop   (q_pop),
    .results (results)
  );

  // The front end's credit check must keep the queue from overflowing.
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_stat.level < FIFO_LVL_W'(FIFO_DEPTH)))
    else $error("queue push while full");

  // The back end only takes an item that is present.
  a_queue_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("queue pop while empty");

  // A stalled output must freeze the back end, so nothing leaves the queue.
  a_stall_holds_queue: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.ready) |-> !q_pop)
    else $error("queue popped while output stalled");

endmodule
